FILE: hw/rtl/mtdq_pkg.sv
// ---------------------------------------------------------------------------
// mtdq_pkg
// Shared types and constants for the multi-timer deadline queue.
// ---------------------------------------------------------------------------
package mtdq_pkg;

  localparam int ACT_W     = 2;
  localparam int REQ_ID_W  = 16;
  localparam int DELAY_W   = 32;
  localparam int WHICH_W   = 4;
  localparam int TOTAL_W   = 32;
  localparam int CFG_W     = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic KIND_ANSWER    = 1'b0;
  localparam logic KIND_EXPIRY    = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_SET    = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_TICK   = 2'd2
  } act_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_INS_CMP,
    S_INS_SHIFT,
    S_REMOVE,
    S_ANSWER,
    S_HEAD,
    S_EXP_CNT,
    S_EXP_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic ins_cmp;
    logic ins_en;
    logic rem_en;
    logic tick;
    logic head_take;
    logic cnt_upd;
    logic ans_load;
    logic exp_load;
  } ctl_cmd_t;

  typedef struct packed {
    act_t act;
    logic req_ok;
    logic due;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic ins_cmp;
    logic ins_en;
    logic rem_en;
    logic pop_en;
  } q_cmd_t;

endpackage

FILE: hw/rtl/mtdq_in_if.sv
// ---------------------------------------------------------------------------
// mtdq_in_if
// Request channel: set, cancel or tick transactions.
// ---------------------------------------------------------------------------
interface mtdq_in_if;

  logic                                valid;
  logic                                ready;
  logic [mtdq_pkg::ACT_W-1:0]          action;
  logic [mtdq_pkg::REQ_ID_W-1:0]       timer_id;
  logic [mtdq_pkg::DELAY_W-1:0]        delay_ticks;

  modport source (output valid, action, timer_id, delay_ticks, input ready);
  modport sink   (input valid, action, timer_id, delay_ticks, output ready);

endinterface

FILE: hw/rtl/mtdq_out_if.sv
// ---------------------------------------------------------------------------
// mtdq_out_if
// Result channel: status answers and expiry notices.
// ---------------------------------------------------------------------------
interface mtdq_out_if;

  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [mtdq_pkg::WHICH_W-1:0]        which_timer;
  logic                                status;
  logic [mtdq_pkg::TOTAL_W-1:0]        expiry_total;
  logic                                last;

  modport source (output valid, kind, which_timer, status, expiry_total, last,
                  input ready);
  modport sink   (input valid, kind, which_timer, status, expiry_total, last,
                  output ready);

endinterface

FILE: hw/rtl/mtdq_queue.sv
// ---------------------------------------------------------------------------
// mtdq_queue
// Deadline-ordered row of timer slots: insert, remove by id, pop head.
// ---------------------------------------------------------------------------
module mtdq_queue #(
  parameter int TIMER_SLOTS = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mtdq_pkg::q_cmd_t               cmd,
  input  logic [$clog2(TIMER_SLOTS)-1:0] new_id,
  input  logic [TIME_BITS-1:0]           new_dl,
  input  logic [$clog2(TIMER_SLOTS)-1:0] rem_id,
  input  logic [TIME_BITS-1:0]           now,
  output logic [$clog2(TIMER_SLOTS)-1:0] head_id,
  output logic                           due
);

  localparam int IDW = $clog2(TIMER_SLOTS);
  localparam int LW  = $clog2(TIMER_SLOTS + 1);

  logic [TIME_BITS-1:0]   dl_r    [TIMER_SLOTS];
  logic [IDW-1:0]         id_r    [TIMER_SLOTS];
  logic [TIME_BITS-1:0]   prev_dl [TIMER_SLOTS];
  logic [IDW-1:0]         prev_id [TIMER_SLOTS];
  logic [TIME_BITS-1:0]   next_dl [TIMER_SLOTS];
  logic [IDW-1:0]         next_id [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] prev_keep;
  logic [TIMER_SLOTS-1:0] in_use_c;
  logic [TIMER_SLOTS-1:0] keep_c;
  logic [TIMER_SLOTS-1:0] keep_r;
  logic [TIMER_SLOTS-1:0] match_c;
  logic [TIMER_SLOTS-1:0] gone_c;
  logic [LW-1:0]          len_r;
  logic [LW-1:0]          len_nxt;

  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_slot
    assign in_use_c[g] = LW'(g) < len_r;
    assign keep_c[g]   = in_use_c[g] && (dl_r[g] <= new_dl);
    assign match_c[g]  = in_use_c[g] && (id_r[g] == rem_id);
    assign gone_c[g]   = |match_c[g:0];

    if (g == 0) begin : g_first
      assign prev_keep[g] = 1'b1;
      assign prev_dl[g]   = new_dl;
      assign prev_id[g]   = new_id;
    end else begin : g_rest
      assign prev_keep[g] = keep_r[g-1];
      assign prev_dl[g]   = dl_r[g-1];
      assign prev_id[g]   = id_r[g-1];
    end

    if (g == TIMER_SLOTS - 1) begin : g_tail
      assign next_dl[g] = dl_r[g];
      assign next_id[g] = id_r[g];
    end else begin : g_body
      assign next_dl[g] = dl_r[g+1];
      assign next_id[g] = id_r[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.ins_en) begin
        if (!keep_r[g]) begin
          if (prev_keep[g]) begin
            dl_r[g] <= new_dl;
            id_r[g] <= new_id;
          end else begin
            dl_r[g] <= prev_dl[g];
            id_r[g] <= prev_id[g];
          end
        end
      end else if (cmd.pop_en || (cmd.rem_en && gone_c[g])) begin
        dl_r[g] <= next_dl[g];
        id_r[g] <= next_id[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_cmp) begin
      keep_r <= keep_c;
    end
  end

  always_comb begin
    len_nxt = len_r;
    priority if (cmd.ins_en) begin
      len_nxt = len_r + LW'(1);
    end else if (cmd.rem_en || cmd.pop_en) begin
      len_nxt = len_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  assign head_id = id_r[0];
  assign due     = (len_r != '0) && (dl_r[0] <= now);

endmodule

FILE: hw/rtl/mtdq_ctrl.sv
// ---------------------------------------------------------------------------
// mtdq_ctrl
// Sequencer for request handling and expiry release.
// ---------------------------------------------------------------------------
module mtdq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mtdq_pkg::dp_stat_t  stat,
  output mtdq_pkg::ctl_cmd_t  cmd
);

  mtdq_pkg::state_t state_r;
  mtdq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mtdq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      mtdq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = mtdq_pkg::S_LOOKUP;
        end
      end
      mtdq_pkg::S_LOOKUP: begin
        unique case (stat.act)
          mtdq_pkg::ACT_SET: begin
            cmd.lookup = 1'b1;
            state_nxt  = stat.req_ok ? mtdq_pkg::S_INS_CMP : mtdq_pkg::S_ANSWER;
          end
          mtdq_pkg::ACT_CANCEL: begin
            cmd.lookup = 1'b1;
            state_nxt  = stat.req_ok ? mtdq_pkg::S_REMOVE : mtdq_pkg::S_ANSWER;
          end
          mtdq_pkg::ACT_TICK: begin
            cmd.tick  = 1'b1;
            state_nxt = mtdq_pkg::S_HEAD;
          end
          default: begin
            state_nxt = mtdq_pkg::S_IDLE;
          end
        endcase
      end
      mtdq_pkg::S_INS_CMP: begin
        cmd.ins_cmp = 1'b1;
        state_nxt   = mtdq_pkg::S_INS_SHIFT;
      end
      mtdq_pkg::S_INS_SHIFT: begin
        cmd.ins_en = 1'b1;
        state_nxt  = mtdq_pkg::S_ANSWER;
      end
      mtdq_pkg::S_REMOVE: begin
        cmd.rem_en = 1'b1;
        state_nxt  = mtdq_pkg::S_ANSWER;
      end
      mtdq_pkg::S_ANSWER: begin
        if (stat.out_free) begin
          cmd.ans_load = 1'b1;
          state_nxt    = mtdq_pkg::S_IDLE;
        end
      end
      mtdq_pkg::S_HEAD: begin
        if (stat.due) begin
          cmd.head_take = 1'b1;
          state_nxt     = mtdq_pkg::S_EXP_CNT;
        end else begin
          state_nxt = mtdq_pkg::S_IDLE;
        end
      end
      mtdq_pkg::S_EXP_CNT: begin
        cmd.cnt_upd = 1'b1;
        state_nxt   = mtdq_pkg::S_EXP_OUT;
      end
      mtdq_pkg::S_EXP_OUT: begin
        if (stat.out_free) begin
          cmd.exp_load = 1'b1;
          state_nxt    = stat.due ? mtdq_pkg::S_HEAD : mtdq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mtdq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/mtdq_dpath.sv
// ---------------------------------------------------------------------------
// mtdq_dpath
// Request registers, time counter, armed flags, expiry counters, result
// register and the deadline queue.
// ---------------------------------------------------------------------------
module mtdq_dpath #(
  parameter int TIMER_SLOTS = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mtdq_pkg::ctl_cmd_t                 cmd,
  output mtdq_pkg::dp_stat_t                 stat,
  input  logic                               cfg_we,
  input  logic [mtdq_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic [mtdq_pkg::ACT_W-1:0]         in_action,
  input  logic [mtdq_pkg::REQ_ID_W-1:0]      in_timer_id,
  input  logic [mtdq_pkg::DELAY_W-1:0]       in_delay_ticks,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_kind,
  output logic [mtdq_pkg::WHICH_W-1:0]       out_which_timer,
  output logic                               out_status,
  output logic [mtdq_pkg::TOTAL_W-1:0]       out_expiry_total,
  output logic                               out_last
);

  localparam int IDW = $clog2(TIMER_SLOTS);
  localparam int TW1 = TIME_BITS + 1;

  mtdq_pkg::act_t                    act_r;
  logic [mtdq_pkg::REQ_ID_W-1:0]     id_r;
  logic [mtdq_pkg::DELAY_W-1:0]      delay_r;
  logic [mtdq_pkg::CFG_W-1:0]        cfg_r;
  logic [TIME_BITS-1:0]              now_r;
  logic [TIME_BITS-1:0]              new_dl_r;
  logic [TIMER_SLOTS-1:0]            armed_r;
  logic                              refused_r;
  logic [mtdq_pkg::TOTAL_W-1:0]      cnt_mem [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0]            cnt_vld_r;
  logic [mtdq_pkg::TOTAL_W-1:0]      rd_q_r;
  logic                              rd_vld_r;
  logic [IDW-1:0]                    exp_id_r;
  logic [mtdq_pkg::TOTAL_W-1:0]      total_r;

  logic                              out_valid_r;
  logic                              out_kind_r;
  logic [mtdq_pkg::WHICH_W-1:0]      out_which_r;
  logic                              out_status_r;
  logic [mtdq_pkg::TOTAL_W-1:0]      out_total_r;
  logic                              out_last_r;

  logic [IDW-1:0]                    id_idx;
  logic                              req_valid;
  logic                              req_armed;
  logic                              req_ok;
  logic [TW1-1:0]                    dl_sum;
  logic [TIME_BITS-1:0]              dl_sat;
  logic [IDW-1:0]                    head_id;
  logic                              due;
  logic [IDW-1:0]                    rd_addr;
  logic                              rd_en;
  logic [mtdq_pkg::TOTAL_W-1:0]      cnt_cur;
  logic [mtdq_pkg::TOTAL_W-1:0]      cnt_inc;
  logic [mtdq_pkg::TOTAL_W-1:0]      ans_total;
  logic                              out_free;
  mtdq_pkg::q_cmd_t                  q_cmd;

  assign id_idx    = id_r[IDW-1:0];
  assign req_valid = (32'(id_r) < 32'(cfg_r)) && (32'(id_r) < 32'(TIMER_SLOTS));
  assign req_armed = req_valid && armed_r[id_idx];

  always_comb begin
    unique case (act_r)
      mtdq_pkg::ACT_SET:    req_ok = req_valid && !req_armed;
      mtdq_pkg::ACT_CANCEL: req_ok = req_armed;
      default:              req_ok = 1'b0;
    endcase
  end

  assign dl_sum = {1'b0, now_r} + TW1'(delay_r);
  assign dl_sat = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];

  assign rd_en   = cmd.lookup || cmd.head_take;
  assign rd_addr = cmd.head_take ? head_id : id_idx;

  assign cnt_cur   = rd_vld_r ? rd_q_r : '0;
  assign cnt_inc   = (&cnt_cur) ? cnt_cur : cnt_cur + 32'd1;
  assign ans_total = req_valid ? cnt_cur : '0;
  assign out_free  = !out_valid_r || out_ready;

  assign q_cmd.ins_cmp = cmd.ins_cmp;
  assign q_cmd.ins_en  = cmd.ins_en;
  assign q_cmd.rem_en  = cmd.rem_en;
  assign q_cmd.pop_en  = cmd.head_take;

  mtdq_queue #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .TIME_BITS   (TIME_BITS)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (q_cmd),
    .new_id  (id_idx),
    .new_dl  (new_dl_r),
    .rem_id  (id_idx),
    .now     (now_r),
    .head_id (head_id),
    .due     (due)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= mtdq_pkg::act_t'(in_action);
      id_r    <= in_timer_id;
      delay_r <= in_delay_ticks;
    end
    if (cmd.lookup) begin
      new_dl_r  <= dl_sat;
      refused_r <= !req_ok;
    end
    if (rd_en) begin
      rd_q_r   <= cnt_mem[rd_addr];
      rd_vld_r <= cnt_vld_r[rd_addr];
    end
    if (cmd.head_take) begin
      exp_id_r <= head_id;
    end
    if (cmd.cnt_upd) begin
      cnt_mem[exp_id_r] <= cnt_inc;
      total_r           <= cnt_inc;
    end
    if (cmd.ans_load) begin
      out_kind_r   <= mtdq_pkg::KIND_ANSWER;
      out_which_r  <= id_r[mtdq_pkg::WHICH_W-1:0];
      out_status_r <= refused_r ? mtdq_pkg::STATUS_REFUSED : mtdq_pkg::STATUS_OK;
      out_total_r  <= ans_total;
      out_last_r   <= 1'b1;
    end else if (cmd.exp_load) begin
      out_kind_r   <= mtdq_pkg::KIND_EXPIRY;
      out_which_r  <= mtdq_pkg::WHICH_W'(exp_id_r);
      out_status_r <= mtdq_pkg::STATUS_OK;
      out_total_r  <= total_r;
      out_last_r   <= !due;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= mtdq_pkg::CFG_RESET;
      now_r       <= '0;
      armed_r     <= '0;
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (cmd.tick) begin
        now_r <= now_r + TIME_BITS'(1);
      end
      if (cmd.ins_en) begin
        armed_r[id_idx] <= 1'b1;
      end else if (cmd.rem_en) begin
        armed_r[id_idx] <= 1'b0;
      end else if (cmd.head_take) begin
        armed_r[head_id] <= 1'b0;
      end
      if (cmd.cnt_upd) begin
        cnt_vld_r[exp_id_r] <= 1'b1;
      end
      if (cmd.ans_load || cmd.exp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.act      = act_r;
  assign stat.req_ok   = req_ok;
  assign stat.due      = due;
  assign stat.out_free = out_free;

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_which_timer  = out_which_r;
  assign out_status       = out_status_r;
  assign out_expiry_total = out_total_r;
  assign out_last         = out_last_r;

endmodule

FILE: hw/rtl/multi_timer_deadline_queue_top.sv
// Set or cancel: a refused request is answered straight after lookup, a cancel removes
// its entry first and a set compares and then shifts the queue; the block stays busy until
// the answer loads, then takes the next request. Tick: if nothing is due the block is idle
// again after the time step, else each released timer goes through take head, counter
// read-modify-write and result load. One transaction in flight; a stalled sink holds the block.
// Reset clears time, queue length, armed flags and counter valid bits at once; no sweep.
// ---------------------------------------------------------------------------
// multi_timer_deadline_queue_top
// Bank of one-shot timers released in deadline order on each tick.
// ---------------------------------------------------------------------------
module multi_timer_deadline_queue_top #(
  parameter int TIMER_SLOTS = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mtdq_in_if.sink                     in_if,
  mtdq_out_if.source                  out_if,
  input  logic                        cfg_we,
  input  logic [mtdq_pkg::CFG_W-1:0]  cfg_wdata
);

  mtdq_pkg::ctl_cmd_t cmd;
  mtdq_pkg::dp_stat_t stat;
  logic               in_ready;

  assign in_if.ready = in_ready;

  mtdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mtdq_dpath #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .TIME_BITS   (TIME_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_action        (in_if.action),
    .in_timer_id      (in_if.timer_id),
    .in_delay_ticks   (in_if.delay_ticks),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_kind         (out_if.kind),
    .out_which_timer  (out_if.which_timer),
    .out_status       (out_if.status),
    .out_expiry_total (out_if.expiry_total),
    .out_last         (out_if.last)
  );

  a_queue_ops_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ins_en, cmd.rem_en, cmd.head_take}))
    else $error("queue update commands overlap");

  a_take_only_when_due: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.head_take |-> stat.due)
    else $error("head taken while not due");

  a_answer_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.kind == mtdq_pkg::KIND_ANSWER)) |-> out_if.last)
    else $error("status answer without last");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("second transaction taken while busy");

endmodule
